>>> src/mct_pkg.sv
// Package: shared constants, types and codes for the 4x4 matrix column transform.
`timescale 1ns / 1ps
`default_nettype none
package mct_pkg;

  localparam int MATRIX_DIM = 4;
  localparam int FRAC_BITS  = 16;
  localparam int ELEM_W     = 32;
  localparam int IDX_W      = 2;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int SUM_W      = PROD_W + 3;

  localparam logic signed [SUM_W-1:0] ROUND_ADD =
    (FRAC_BITS > 0) ? (SUM_W'(1) << (FRAC_BITS - 1)) : '0;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sh0000_0000_8000_0000);

  typedef logic [MATRIX_DIM-1:0][ELEM_W-1:0] vec_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } ctrl_t;

endpackage
`default_nettype wire

>>> src/mct_lane.sv
// Lane: one dot product of a stored row with the incoming column, rounded and saturated.
`timescale 1ns / 1ps
`default_nettype none
module mct_lane (
  input  wire logic          clk,
  input  wire mct_pkg::vec_t  row,
  input  wire mct_pkg::vec_t  col,
  input  wire mct_pkg::ctrl_t ctrl,
  output logic [mct_pkg::ELEM_W-1:0] result,
  output logic                       sat
);

  logic signed [mct_pkg::PROD_W-1:0] prod [mct_pkg::MATRIX_DIM];
  logic signed [mct_pkg::SUM_W-1:0]  sum;
  logic signed [mct_pkg::SUM_W-1:0]  sum_next;
  logic signed [mct_pkg::SUM_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      for (int k = 0; k < mct_pkg::MATRIX_DIM; k++) begin
        prod[k] <= $signed(row[k]) * $signed(col[k]);
      end
    end
  end

  always_comb begin
    sum_next = mct_pkg::ROUND_ADD;
    for (int k = 0; k < mct_pkg::MATRIX_DIM; k++) begin
      sum_next = sum_next + mct_pkg::SUM_W'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      sum <= sum_next;
    end
  end

  always_comb begin
    shifted = sum >>> mct_pkg::FRAC_BITS;
    if (shifted > mct_pkg::SAT_MAX) begin
      result = mct_pkg::SAT_MAX[mct_pkg::ELEM_W-1:0];
      sat    = 1'b1;
    end else if (shifted < mct_pkg::SAT_MIN) begin
      result = mct_pkg::SAT_MIN[mct_pkg::ELEM_W-1:0];
      sat    = 1'b1;
    end else begin
      result = shifted[mct_pkg::ELEM_W-1:0];
      sat    = 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> src/mct_merge.sv
// Merge stage: output register that gathers the lane results and combines their saturation flags.
`timescale 1ns / 1ps
`default_nettype none
module mct_merge (
  input  wire logic                          clk,
  input  wire mct_pkg::ctrl_t                ctrl,
  input  wire mct_pkg::idx_t                 col_in,
  input  wire mct_pkg::vec_t                 lane_val,
  input  wire logic [mct_pkg::MATRIX_DIM-1:0] lane_sat,
  output mct_pkg::vec_t                      data,
  output mct_pkg::idx_t                      column_number,
  output logic                               overflow
);

  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      data          <= lane_val;
      column_number <= col_in;
      overflow      <= |lane_sat;
    end
  end

endmodule
`default_nettype wire

>>> src/matrix4_column_transform_core.sv
// Top level: 4x4 fixed-point matrix product, one column of the result per word.
//
// Input stream (s_*): each word carries one row or one column of four Q16.16
// elements. s_tuser[0] is the opcode: load writes row s_tuser[2:1] of the left
// matrix and gives no output; transform multiplies the stored matrix by the
// column and gives one output word for column s_tuser[2:1].
// Output stream (m_*): four saturated Q16.16 elements of the product column,
// the column number and an overflow flag set when any element saturated.
// Pipeline: multiply register, sum register, output register; a transform
// passes each of them before it shows on m_tvalid. Throughput is one word per
// cycle unless m_tready stalls; four lanes of four 32x32 multipliers each work in parallel.
// A load takes effect at its accept edge, so a transform in the next cycle
// already sees the new row.
// Reset clears the stored matrix to zero and empties the pipeline; s_tready
// is low while rst is high. When the receiver stalls, bubbles in the pipeline
// are filled first, then s_tready drops; no word is lost.
`timescale 1ns / 1ps
`default_nettype none
module matrix4_column_transform_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,   // elem0, elem1, elem2, elem3
  input  wire logic [2:0]   s_tuser,   // opcode, index[1:0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,   // out0, out1, out2, out3
  output logic [2:0]        m_tuser    // column_number[1:0], overflow
);

  mct_pkg::vec_t  rows [mct_pkg::MATRIX_DIM];
  mct_pkg::vec_t  in_vec;
  mct_pkg::vec_t  lane_val;
  mct_pkg::vec_t  out_vec;
  mct_pkg::idx_t  in_idx;
  mct_pkg::idx_t  col1;
  mct_pkg::idx_t  col2;
  mct_pkg::idx_t  out_col;
  mct_pkg::op_t   in_op;
  mct_pkg::ctrl_t ctrl;
  logic [mct_pkg::MATRIX_DIM-1:0] lane_sat;
  logic v1;
  logic v2;
  logic v3;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic out_ovf;
  logic acc;

  assign in_vec = s_tdata;
  assign in_op  = mct_pkg::op_t'(s_tuser[0]);
  assign in_idx = s_tuser[2:1];

  assign rdy3 = !v3 || m_tready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign s_tready = rdy1 && !rst;
  assign acc      = s_tvalid && s_tready;

  assign ctrl.en1 = rdy1;
  assign ctrl.en2 = rdy2;
  assign ctrl.en3 = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < mct_pkg::MATRIX_DIM; r++) begin
        rows[r] <= '0;
      end
    end else if (acc && in_op == mct_pkg::OP_LOAD) begin
      rows[in_idx] <= in_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= acc && in_op == mct_pkg::OP_XFORM;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      col1 <= in_idx;
    end
    if (rdy2) begin
      col2 <= col1;
    end
  end

  for (genvar r = 0; r < mct_pkg::MATRIX_DIM; r++) begin : g_lane
    mct_lane u_lane (
      .clk    (clk),
      .row    (rows[r]),
      .col    (in_vec),
      .ctrl   (ctrl),
      .result (lane_val[r]),
      .sat    (lane_sat[r])
    );
  end

  mct_merge u_merge (
    .clk           (clk),
    .ctrl          (ctrl),
    .col_in        (col2),
    .lane_val      (lane_val),
    .lane_sat      (lane_sat),
    .data          (out_vec),
    .column_number (out_col),
    .overflow      (out_ovf)
  );

  assign m_tvalid = v3;
  assign m_tdata  = out_vec;
  assign m_tuser  = {out_ovf, out_col};

endmodule
`default_nettype wire

>>> src/mct_checker.sv
// Checker: port-level properties of the matrix column transform, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mct_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic [2:0]   s_tuser,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [127:0] m_tdata,
  input wire logic [2:0]   m_tuser
);

  logic xform_acc;
  assign xform_acc = s_tvalid && s_tready && s_tuser[0] == mct_pkg::OP_XFORM;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |-> !s_tready ##1 !m_tvalid)
    else $error("pipeline not empty after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(xform_acc, 3))
    else $error("output word without a transform three cycles earlier");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !$past(xform_acc, 1) && !$past(xform_acc, 2) && !xform_acc
      |=> ##1 !m_tvalid)
    else $error("output word without a transform");

endmodule

bind matrix4_column_transform_core mct_checker u_mct_checker (.*);
`default_nettype wire
